/* sv/bal_pkg.sv */
package bal_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NLEN_W   = 7;
  localparam int unsigned COUNT_W  = 7;

  // read_value for anything that is not a successful read
  localparam logic [WORD_W-1:0] NOT_READ = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_DROP   = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_SETLEN = 3'd4,
    KIND_READ   = 3'd5
  } kind_e;

endpackage

/* sv/bal_cmd_if.sv */
interface bal_cmd_if import bal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;
  logic [NLEN_W-1:0]        new_length;

  modport source (output valid, kind, position, value, new_length, input ready);
  modport sink   (input valid, kind, position, value, new_length, output ready);
endinterface

/* sv/bal_res_if.sv */
interface bal_res_if import bal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic                     read_valid;
  logic [COUNT_W-1:0]       count;
  logic                     is_empty;
  logic                     rejected;

  modport source (output valid, read_value, read_valid, count, is_empty, rejected,
                  input ready);
  modport sink   (input valid, read_value, read_valid, count, is_empty, rejected,
                  output ready);
endinterface

/* sv/bal_store.sv */
module bal_store import bal_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WORD_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WORD_W-1:0]        rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bal_ctrl.sv */
module bal_ctrl import bal_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bal_cmd_if.sink                  cmd_i,
  bal_res_if.source                res_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [WORD_W-1:0]        mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  logic [WORD_W-1:0]        mem_rdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_SHIFT, ST_TAIL, ST_PUT, ST_FILL, ST_READW, ST_FIN
  } state_e;

  state_e             state_q, state_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [WORD_W-1:0]  val_q, val_d;
  logic [NLEN_W-1:0]  nlen_q, nlen_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      last_q, last_d;
  logic [AW-1:0]      wr_q, wr_d;
  logic               pend_q, pend_d;
  logic               up_q, up_d;
  logic [WORD_W-1:0]  rval_q, rval_d;
  logic               rvld_q, rvld_d;
  logic               rej_q, rej_d;
  logic               ovalid_q, ovalid_d;
  logic [WORD_W-1:0]  oval_q, oval_d;
  logic               orvld_q, orvld_d;
  logic [COUNT_W-1:0] ocount_q, ocount_d;
  logic               oempty_q, oempty_d;
  logic               orej_q, orej_d;

  logic [XW-1:0] pos_x, count_x, nlen_x, depth_x;
  logic          pos_lt, not_full;

  assign pos_x    = XW'(pos_q);
  assign count_x  = XW'(count_q);
  assign nlen_x   = XW'(nlen_q);
  assign depth_x  = XW'(DEPTH);
  assign pos_lt   = pos_x < count_x;
  assign not_full = count_x < depth_x;

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    pos_d    = pos_q;
    val_d    = val_q;
    nlen_d   = nlen_q;
    count_d  = count_q;
    idx_d    = idx_q;
    last_d   = last_q;
    wr_d     = wr_q;
    pend_d   = pend_q;
    up_d     = up_q;
    rval_d   = rval_q;
    rvld_d   = rvld_q;
    rej_d    = rej_q;
    ovalid_d = ovalid_q;
    oval_d   = oval_q;
    orvld_d  = orvld_q;
    ocount_d = ocount_q;
    oempty_d = oempty_q;
    orej_d   = orej_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;

    if (ovalid_q && res_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          kind_d  = cmd_i.kind;
          pos_d   = cmd_i.position;
          val_d   = cmd_i.value;
          nlen_d  = cmd_i.new_length;
          rval_d  = NOT_READ;
          rvld_d  = 1'b0;
          rej_d   = 1'b0;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FIN;
        unique case (kind_q)
          KIND_APPEND: begin
            if (not_full) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = count_q[AW-1:0];
              mem_wdata_o = val_q;
              count_d     = count_q + CW'(1);
            end else begin
              rej_d = 1'b1;
            end
          end
          KIND_DROP: begin
            if (count_q != '0) begin
              count_d = count_q - CW'(1);
            end
          end
          KIND_INSERT: begin
            // move entries up from the tail, then drop the word in
            if (pos_lt && not_full) begin
              idx_d   = count_q[AW-1:0] - AW'(1);
              last_d  = pos_x[AW-1:0];
              up_d    = 1'b0;
              pend_d  = 1'b0;
              state_d = ST_SHIFT;
            end
          end
          KIND_ERASE: begin
            if (pos_lt) begin
              if (pos_x + XW'(1) == count_x) begin
                count_d = count_q - CW'(1);
              end else begin
                idx_d   = pos_x[AW-1:0] + AW'(1);
                last_d  = count_q[AW-1:0] - AW'(1);
                up_d    = 1'b1;
                pend_d  = 1'b0;
                state_d = ST_SHIFT;
              end
            end
          end
          KIND_SETLEN: begin
            if (nlen_x > depth_x) begin
              rej_d = 1'b1;
            end else if (count_x < nlen_x) begin
              idx_d   = count_q[AW-1:0];
              last_d  = nlen_x[AW-1:0] - AW'(1);
              state_d = ST_FILL;
            end else begin
              count_d = nlen_x[CW-1:0];
            end
          end
          KIND_READ: begin
            if (pos_lt) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = pos_x[AW-1:0];
              state_d     = ST_READW;
            end
          end
          default: ;
        endcase
      end
      ST_SHIFT: begin
        // read one entry, write back the one read last cycle
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q;
        if (pend_q) begin
          mem_we_o = 1'b1;
        end
        pend_d = 1'b1;
        wr_d   = up_q ? idx_q - AW'(1) : idx_q + AW'(1);
        if (idx_q == last_q) begin
          state_d = ST_TAIL;
        end else begin
          idx_d = up_q ? idx_q + AW'(1) : idx_q - AW'(1);
        end
      end
      ST_TAIL: begin
        mem_we_o = 1'b1;
        if (up_q) begin
          count_d = count_q - CW'(1);
          state_d = ST_FIN;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = last_q;
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        state_d     = ST_FIN;
      end
      ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = '0;
        if (idx_q == last_q) begin
          count_d = nlen_x[CW-1:0];
          state_d = ST_FIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_READW: begin
        rval_d  = mem_rdata_i;
        rvld_d  = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ovalid_q || res_o.ready) begin
          ovalid_d = 1'b1;
          oval_d   = rval_q;
          orvld_d  = rvld_q;
          ocount_d = count_x[COUNT_W-1:0];
          oempty_d = (count_q == '0);
          orej_d   = rej_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      kind_q   <= '0;
      pos_q    <= '0;
      val_q    <= '0;
      nlen_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      last_q   <= '0;
      wr_q     <= '0;
      pend_q   <= 1'b0;
      up_q     <= 1'b0;
      rval_q   <= '0;
      rvld_q   <= 1'b0;
      rej_q    <= 1'b0;
      ovalid_q <= 1'b0;
      oval_q   <= '0;
      orvld_q  <= 1'b0;
      ocount_q <= '0;
      oempty_q <= 1'b0;
      orej_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      pos_q    <= pos_d;
      val_q    <= val_d;
      nlen_q   <= nlen_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      last_q   <= last_d;
      wr_q     <= wr_d;
      pend_q   <= pend_d;
      up_q     <= up_d;
      rval_q   <= rval_d;
      rvld_q   <= rvld_d;
      rej_q    <= rej_d;
      ovalid_q <= ovalid_d;
      oval_q   <= oval_d;
      orvld_q  <= orvld_d;
      ocount_q <= ocount_d;
      oempty_q <= oempty_d;
      orej_q   <= orej_d;
    end
  end

  assign cmd_i.ready      = (state_q == ST_IDLE);
  assign res_o.valid      = ovalid_q;
  assign res_o.read_value = oval_q;
  assign res_o.read_valid = orvld_q;
  assign res_o.count      = ocount_q;
  assign res_o.is_empty   = oempty_q;
  assign res_o.rejected   = orej_q;

endmodule

/* sv/bounded_array_list_engine.sv */
// Channel | Dir | Word
// --------+-----+-----------------------------------------------------------
// cmd_i   | in  | kind, position, value, new_length
// res_o   | out | read_value, read_valid, count, is_empty, rejected
//
// One word in, one word out, one command at a time. Append, drop, set length
// without fill and out-of-range commands go from decode straight to the result
// register; a read first waits in ST_READW for the registered store read. Insert
// and erase move one entry per cycle through the store's read and write ports.
// Set length zero-fills one entry per cycle.
// Reset empties the list (count to zero); store contents are left as they are.
// A result waiting on res_o does not hold off the next command: it is worked on
// and only waits at the end for the output register to free up.
module bounded_array_list_engine import bal_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bal_cmd_if.sink   cmd_i,
  bal_res_if.source res_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  // store port, driven by the sequencer
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // sequencer: decode, shift/fill walks, count and result register
  bal_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // entry store: one write, one registered read per cycle
  bal_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* bench/tb_bounded_array_list_engine.sv */
module tb_bounded_array_list_engine;
  import bal_pkg::*;

  // List capacity under test; the block is built with the same value.
  localparam int LIST_DEPTH = 64;

  // Kind codes that the package leaves unnamed; the block treats them as no-ops.
  localparam logic [KIND_W-1:0] KIND_NOP_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NOP_B = 3'd7;

  // Idle draw per word on either side is bounded by MAX_GAP.
  localparam int unsigned MAX_GAP      = 13;
  // Random commands, no-ops and ignored ones included.
  localparam int unsigned RANDOM_WORDS = 750;
  localparam int unsigned BLOCK_WORDS  = 50;
  // Long receiver hold-off: starts after HOLD_AT accepted commands.
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_LEN     = 600;
  // Worst single command is a full shift; allow margin.
  localparam int unsigned DRAIN_CYCLES = LIST_DEPTH + 20;
  // Several times the slowest correct run of roughly 800 words.
  localparam int unsigned LIMIT_CYCLES = 500000;

  typedef enum logic [1:0] {
    LOAD_GROW,
    LOAD_SHRINK,
    LOAD_MIX
  } load_mode_e;

  // Order of kinds in the weight table below.
  localparam kind_e KIND_ORDER [6] = '{KIND_APPEND, KIND_DROP, KIND_INSERT,
                                       KIND_ERASE, KIND_SETLEN, KIND_READ};
  // Cumulative weights out of 100 per load mode; remainder goes to no-ops.
  localparam int unsigned KIND_BOUND [3][6] = '{
    '{40, 44, 69, 74, 77, 97},   // grow: fills the list, reaches full
    '{10, 30, 40, 65, 72, 97},   // shrink: drains towards empty
    '{20, 28, 48, 63, 72, 97}    // mix
  };

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
    logic [NLEN_W-1:0]        new_length;
    int unsigned              gap;       // idle cycles offered before this word
  } list_cmd_t;

  typedef struct {
    logic signed [WORD_W-1:0] read_value;
    logic                     read_valid;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     rejected;
  } list_res_t;

  // Entries at and above len are stale and never read.
  typedef struct {
    logic signed [WORD_W-1:0] mem [LIST_DEPTH];
    int                       len;
  } list_state_t;

  logic clk_i;
  logic rst_ni;

  bal_cmd_if cmd_if ();
  bal_res_if res_if ();

  bounded_array_list_engine #(
    .DEPTH (LIST_DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  list_cmd_t   pending_cmds [$];      // stimulus not yet offered
  list_res_t   expected_results [$];  // predictions awaiting their result word
  list_state_t gen_state;             // tracks the list while stimulus is built
  list_state_t pred_state;            // tracks the list as commands are accepted
  bit          gen_burst;             // no sender gaps for the current block
  bit          res_burst;             // no receiver stalls for a while
  int unsigned cmds_accepted;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned wait_cnt;
  int unsigned stall_left;
  int unsigned hold_cnt;
  logic        hold;
  logic        hold_done;

  always #5 clk_i = ~clk_i;

  // Applies one command to a list state and returns the result word it yields.
  function automatic list_res_t list_apply(inout list_state_t st, input list_cmd_t c);
    list_res_t r;
    int        i;
    r.read_value = NOT_READ;
    r.read_valid = 1'b0;
    r.rejected   = 1'b0;
    case (c.kind)
      KIND_APPEND: begin
        if (st.len < LIST_DEPTH) begin
          st.mem[st.len] = c.value;
          st.len++;
        end else begin
          r.rejected = 1'b1;
        end
      end
      KIND_DROP: begin
        if (st.len > 0) st.len--;
      end
      KIND_INSERT: begin
        // only below the count, and silently dropped on a full list
        if (int'(c.position) < st.len && st.len < LIST_DEPTH) begin
          for (i = st.len; i > int'(c.position); i--) st.mem[i] = st.mem[i-1];
          st.mem[c.position] = c.value;
          st.len++;
        end
      end
      KIND_ERASE: begin
        if (int'(c.position) < st.len) begin
          for (i = c.position; i + 1 < st.len; i++) st.mem[i] = st.mem[i+1];
          st.len--;
        end
      end
      KIND_SETLEN: begin
        if (int'(c.new_length) > LIST_DEPTH) begin
          r.rejected = 1'b1;
        end else begin
          for (i = st.len; i < int'(c.new_length); i++) st.mem[i] = '0;
          st.len = int'(c.new_length);
        end
      end
      KIND_READ: begin
        if (int'(c.position) < st.len) begin
          r.read_value = st.mem[c.position];
          r.read_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.count    = st.len[COUNT_W-1:0];
    r.is_empty = (st.len == 0);
    return r;
  endfunction

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Queues one command; returns 1 unless the block will merely ignore it.
  function automatic bit queue_cmd(logic [KIND_W-1:0] kind, logic [POS_W-1:0] position,
                                   logic [WORD_W-1:0] value,
                                   logic [NLEN_W-1:0] new_length);
    list_cmd_t c;
    list_res_t r;
    int        len_before;
    c.kind       = kind;
    c.position   = position;
    c.value      = value;
    c.new_length = new_length;
    c.gap        = draw_gap(gen_burst);
    len_before   = gen_state.len;
    r            = list_apply(gen_state, c);
    pending_cmds.insert(pending_cmds.size(), c);
    if (kind == KIND_NOP_A || kind == KIND_NOP_B) return 1'b0;
    if (kind == KIND_READ || kind == KIND_SETLEN || r.rejected) return 1'b1;
    return gen_state.len != len_before;
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly an index inside the list, sometimes anywhere in the field.
  function automatic logic [POS_W-1:0] pick_position();
    if (gen_state.len > 0 && $urandom_range(0, 99) < 85)
      return POS_W'($urandom_range(0, gen_state.len - 1));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  function automatic logic [NLEN_W-1:0] pick_length();
    case ($urandom_range(0, 6))
      0:       return NLEN_W'(LIST_DEPTH);
      1:       return NLEN_W'($urandom_range(LIST_DEPTH + 1, (1 << NLEN_W) - 1));
      2:       return NLEN_W'($urandom_range(0, 4));
      default: return NLEN_W'($urandom_range(0, LIST_DEPTH));
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(load_mode_e mode);
    int unsigned roll;
    int          k;
    roll = $urandom_range(0, 99);
    for (k = 0; k < 6; k++)
      if (roll < KIND_BOUND[mode][k]) return KIND_ORDER[k];
    return $urandom_range(0, 1) ? KIND_NOP_A : KIND_NOP_B;
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Sender: offers queued words, honouring each word's idle gap. A word is
  // predicted at the edge where it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid      <= 1'b0;
      cmd_if.kind       <= '0;
      cmd_if.position   <= '0;
      cmd_if.value      <= '0;
      cmd_if.new_length <= '0;
      wait_cnt          <= 0;
      cmds_accepted     <= 0;
    end else begin : drive
      list_cmd_t cur;
      list_res_t pred;
      if (cmd_if.valid && cmd_if.ready) begin
        cur.kind       = cmd_if.kind;
        cur.position   = cmd_if.position;
        cur.value      = cmd_if.value;
        cur.new_length = cmd_if.new_length;
        cur.gap        = 0;
        pred           = list_apply(pred_state, cur);
        expected_results.insert(expected_results.size(), pred);
        cmds_accepted <= cmds_accepted + 1;
      end
      // a held word stays put until taken
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && wait_cnt >= pending_cmds[0].gap) begin
          cmd_if.valid      <= 1'b1;
          cmd_if.kind       <= pending_cmds[0].kind;
          cmd_if.position   <= pending_cmds[0].position;
          cmd_if.value      <= pending_cmds[0].value;
          cmd_if.new_length <= pending_cmds[0].new_length;
          void'(pending_cmds.pop_front());
          wait_cnt <= 0;
        end else begin
          cmd_if.valid <= 1'b0;
          if (pending_cmds.size() != 0) wait_cnt <= wait_cnt + 1;
        end
      end
    end
  end

  // One long receiver hold-off mid-run; the sender keeps offering meanwhile,
  // so the block backs up and stalls its command input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold      <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && cmds_accepted >= HOLD_AT) begin
      hold      <= (hold_cnt != HOLD_LEN - 1);
      hold_done <= (hold_cnt == HOLD_LEN - 1);
      hold_cnt  <= hold_cnt + 1;
    end
  end

  // Receiver: random stall per word, checks each result against the oldest
  // prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
      res_burst    <= 1'b0;
    end else begin : take
      list_res_t   want;
      int unsigned stall_nxt;
      stall_nxt = (stall_left != 0) ? stall_left - 1 : 0;
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no command outstanding");
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_value", want.read_value, res_if.read_value);
          check_field("read_valid", want.read_valid, res_if.read_valid);
          check_field("count",      want.count,      res_if.count);
          check_field("is_empty",   want.is_empty,   res_if.is_empty);
          check_field("rejected",   want.rejected,   res_if.rejected);
        end
        stall_nxt = draw_gap(res_burst);
        // switch between stalling and gapless stretches now and then
        if ($urandom_range(0, 39) == 0) res_burst <= ~res_burst;
      end
      stall_left   <= stall_nxt;
      res_if.ready <= !hold && (stall_nxt == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned done_words;
    int          blk;
    load_mode_e  mode;
    logic [KIND_W-1:0] kind;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.kind       = '0;
    cmd_if.position   = '0;
    cmd_if.value      = '0;
    cmd_if.new_length = '0;
    res_if.ready      = 1'b0;
    cycle_cnt         = 0;
    fail_cnt          = 0;
    gen_state.len     = 0;
    pred_state.len    = 0;
    gen_burst         = 1'b0;

    // Directed: empty-list corner cases first
    void'(queue_cmd(KIND_READ,   6'd0,  32'h1234_5678, 7'd0));  // out of range
    void'(queue_cmd(KIND_DROP,   6'd0,  32'h0,         7'd0));  // drop on empty
    void'(queue_cmd(KIND_INSERT, 6'd0,  32'h1111_1111, 7'd0));  // insert on empty
    void'(queue_cmd(KIND_ERASE,  6'd0,  32'h0,         7'd0));  // erase on empty
    // signed extremes
    void'(queue_cmd(KIND_APPEND, 6'd63, 32'h7FFF_FFFF, 7'd127));
    void'(queue_cmd(KIND_APPEND, 6'd0,  32'h8000_0000, 7'd0));
    void'(queue_cmd(KIND_APPEND, 6'd0,  32'hFFFF_FFFF, 7'd0));
    void'(queue_cmd(KIND_INSERT, 6'd0,  32'h5A5A_5A5A, 7'd0));  // at head
    void'(queue_cmd(KIND_INSERT, 6'd3,  32'hA5A5_A5A5, 7'd0));  // at last index
    void'(queue_cmd(KIND_INSERT, 6'd5,  32'h0BAD_F00D, 7'd0));  // index == count
    void'(queue_cmd(KIND_READ,   6'd0,  32'h0,         7'd0));
    void'(queue_cmd(KIND_READ,   6'd4,  32'h0,         7'd0));
    void'(queue_cmd(KIND_READ,   6'd63, 32'h0,         7'd0));  // beyond count
    void'(queue_cmd(KIND_ERASE,  6'd4,  32'h0,         7'd0));  // last entry
    void'(queue_cmd(KIND_ERASE,  6'd4,  32'h0,         7'd0));  // index == count
    void'(queue_cmd(KIND_NOP_A,  6'd63, 32'hFFFF_FFFF, 7'd127));
    void'(queue_cmd(KIND_NOP_B,  6'd0,  32'h0,         7'd0));
    // grow to full by zero fill, then the full-list cases
    void'(queue_cmd(KIND_SETLEN, 6'd0,  32'h0,         7'd64));
    void'(queue_cmd(KIND_APPEND, 6'd0,  32'h7777_7777, 7'd0));  // rejected
    void'(queue_cmd(KIND_INSERT, 6'd0,  32'h6666_6666, 7'd0));  // ignored, full
    void'(queue_cmd(KIND_READ,   6'd63, 32'h0,         7'd0));  // zero-filled
    void'(queue_cmd(KIND_SETLEN, 6'd0,  32'h0,         7'd65)); // above capacity
    void'(queue_cmd(KIND_SETLEN, 6'd0,  32'h0,         7'd127));
    void'(queue_cmd(KIND_ERASE,  6'd0,  32'h0,         7'd0));  // longest shift down
    void'(queue_cmd(KIND_INSERT, 6'd0,  32'hC0DE_CAFE, 7'd0));  // longest shift up
    void'(queue_cmd(KIND_SETLEN, 6'd0,  32'h0,         7'd0));

    // Random: blocks of one load mode so the list sweeps between empty and full
    done_words = 0;
    blk        = 0;
    mode       = LOAD_MIX;
    while (done_words < RANDOM_WORDS) begin
      if (blk == 0) begin
        mode      = load_mode_e'($urandom_range(0, 2));
        gen_burst = ($urandom_range(0, 3) == 0);
        blk       = BLOCK_WORDS;
      end
      blk--;
      kind = pick_kind(mode);
      void'(queue_cmd(kind, pick_position(), pick_value(),
                      (kind == KIND_SETLEN) ? pick_length() : NLEN_W'($urandom)));
      done_words++;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    // any stray result word shows up in the receiver within this window
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bal_pkg.sv
sv/bal_cmd_if.sv
sv/bal_res_if.sv
sv/bal_store.sv
sv/bal_ctrl.sv
sv/bounded_array_list_engine.sv
bench/tb_bounded_array_list_engine.sv
